FILE: rtl/core/lrukv_pkg.sv
`timescale 1ns / 1ps

package lrukv_pkg;

   // field widths
   localparam int KEY_W  = 32;
   localparam int DATA_W = 32;
   localparam int CAP_W  = 5;

   // defaults
   localparam int          MAX_ENTRIES_DEF = 16;
   localparam logic [CAP_W-1:0] CAP_RESET   = 5'd16;

   // operation codes
   localparam logic FUNC_LOOKUP = 1'b0;
   localparam logic FUNC_STORE  = 1'b1;

   // request item
   typedef struct packed {
      logic                     func;
      logic signed [KEY_W-1:0]  key;
      logic signed [DATA_W-1:0] data_in;
   } req_type;

   // result item
   typedef struct packed {
      logic                     hit;
      logic signed [DATA_W-1:0] data_out;
      logic                     evicted;
      logic signed [KEY_W-1:0]  evicted_key;
   } rsp_type;

   // broadcast control from the sequencer to every cell
   typedef struct packed {
      logic              cmp_en;
      logic              upd_en;
      logic              hit_mode;
      logic              evict;
      logic [KEY_W-1:0]  cmp_key;
   } cell_ctl_type;

   // entry handed from a cell to its older neighbor
   typedef struct packed {
      logic              valid;
      logic [KEY_W-1:0]  key;
      logic [DATA_W-1:0] value;
   } cell_link_type;

   // summary gathered from the oldest cell back toward the head
   typedef struct packed {
      logic              tail;
      logic [DATA_W-1:0] hit_value;
      logic [KEY_W-1:0]  last_key;
   } cell_sum_type;

endpackage

FILE: rtl/core/lrukv_cell.sv
`timescale 1ns / 1ps

module lrukv_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  lrukv_pkg::cell_ctl_type  ctl,
   input  lrukv_pkg::cell_link_type prev_link,
   input  logic                    next_valid,
   input  lrukv_pkg::cell_sum_type  sum_in,
   output lrukv_pkg::cell_link_type link_out,
   output lrukv_pkg::cell_sum_type  sum_out
);

   logic                            valid_ff;
   logic [lrukv_pkg::KEY_W-1:0]     key_ff;
   logic [lrukv_pkg::DATA_W-1:0]    value_ff;
   logic                            match_ff;
   logic                            match_in;
   logic                            tail;
   logic                            last;
   logic                            shift;

   // key compare, registered for the update cycle
   assign match_in = valid_ff && (key_ff == ctl.cmp_key);

   // this cell or an older one holds the hit
   assign tail = match_ff | sum_in.tail;

   // oldest valid entry of the row
   assign last = valid_ff & ~next_valid;

   // take the younger neighbor's entry
   always_comb begin
      if (ctl.hit_mode) begin
         shift = ctl.upd_en & tail;
      end else if (ctl.evict) begin
         shift = ctl.upd_en & valid_ff;
      end else begin
         shift = ctl.upd_en & prev_link.valid;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         if (ctl.cmp_en) begin
            match_ff <= match_in;
         end
         if (shift) begin
            valid_ff <= prev_link.valid;
         end
      end
   end

   // entry payload
   always_ff @(posedge clock) begin
      if (shift) begin
         key_ff   <= prev_link.key;
         value_ff <= prev_link.value;
      end
   end

   assign link_out.valid = valid_ff;
   assign link_out.key   = key_ff;
   assign link_out.value = value_ff;

   // summary toward the head
   assign sum_out.tail      = tail;
   assign sum_out.hit_value = sum_in.hit_value | (match_ff ? value_ff : '0);
   assign sum_out.last_key  = sum_in.last_key | (last ? key_ff : '0);

endmodule

FILE: rtl/core/lrukv_row.sv
`timescale 1ns / 1ps

module lrukv_row #(
   parameter int MAX_ENTRIES = lrukv_pkg::MAX_ENTRIES_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  lrukv_pkg::cell_ctl_type  ctl,
   input  lrukv_pkg::cell_link_type head_link,
   output lrukv_pkg::cell_sum_type  head_sum
);

   lrukv_pkg::cell_link_type links [MAX_ENTRIES+1];
   lrukv_pkg::cell_sum_type  sums  [MAX_ENTRIES+1];
   logic                     next_valid [MAX_ENTRIES];

   // new entry enters at the most recent end
   assign links[0] = head_link;

   // nothing older than the last cell
   assign sums[MAX_ENTRIES] = '0;

   // chain of cells, most recent first
   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      if (i == MAX_ENTRIES - 1) begin : g_end
         assign next_valid[i] = 1'b0;
      end else begin : g_mid
         assign next_valid[i] = links[i+2].valid;
      end

      lrukv_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .prev_link  (links[i]),
         .next_valid (next_valid[i]),
         .sum_in     (sums[i+1]),
         .link_out   (links[i+1]),
         .sum_out    (sums[i])
      );
   end

   assign head_sum = sums[0];

endmodule

FILE: rtl/core/lru_key_value_cache.sv
`timescale 1ns / 1ps

// Fully associative key/value cache with least-recently-used replacement, built
// as a row of cells kept in recency order: the head cell holds the most recent
// entry and the last valid cell the least recent. Each item has a compare cycle
// in which every cell matches the key against its entry into a per-cell
// register, then an update cycle in which hit, lookup data and the evicted key
// are gathered along the row and the cells shift toward the tail to put the
// touched or new entry at the head. The per-cell match register splits compare
// from update; a new item is taken in the update cycle of the previous one if
// the output register is free, and it may enter while the last result still
// waits. A store of a new key evicts the oldest entry once the entry count
// reaches the capacity register (0 acts as 1, values above MAX_ENTRIES act as
// MAX_ENTRIES). Lookup misses return data 0 and change nothing.
module lru_key_value_cache #(
   parameter int MAX_ENTRIES = lrukv_pkg::MAX_ENTRIES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  lrukv_pkg::req_type           req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output lrukv_pkg::rsp_type           rsp_data,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [lrukv_pkg::CAP_W-1:0]  csr_data
);

   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int CMP_W = (CNT_W > lrukv_pkg::CAP_W) ? CNT_W : lrukv_pkg::CAP_W;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_LOOK = 3'b010,
      ST_UPD  = 3'b100
   } state_type;

   state_type                     state_ff, state_in;
   lrukv_pkg::req_type            req_ff;
   lrukv_pkg::rsp_type            rsp_ff, rsp_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [lrukv_pkg::CAP_W-1:0]   cap_ff;
   logic [CNT_W-1:0]              count_ff, count_in;

   logic                          req_fire;
   logic                          out_free;
   logic                          upd_fire;
   logic                          is_store;
   logic                          hit;
   logic                          evict;
   logic [CMP_W-1:0]              cap_ext;
   logic [CMP_W-1:0]              eff_cap;
   logic [CMP_W-1:0]              count_ext;
   lrukv_pkg::cell_ctl_type       ctl;
   lrukv_pkg::cell_link_type      head_link;
   lrukv_pkg::cell_sum_type       head_sum;

   // handshakes
   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) || ((state_ff == ST_UPD) && out_free);
   assign req_fire  = req_valid & req_ready;
   assign upd_fire  = (state_ff == ST_UPD) && out_free;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // capacity clamped to 1..MAX_ENTRIES
   assign cap_ext   = CMP_W'(cap_ff);
   assign count_ext = CMP_W'(count_ff);
   always_comb begin
      if (cap_ext == '0) begin
         eff_cap = CMP_W'(1);
      end else if (cap_ext > CMP_W'(MAX_ENTRIES)) begin
         eff_cap = CMP_W'(MAX_ENTRIES);
      end else begin
         eff_cap = cap_ext;
      end
   end

   // decision for the item in its update cycle
   assign is_store = (req_ff.func == lrukv_pkg::FUNC_STORE);
   assign hit      = head_sum.tail;
   assign evict    = ~hit & is_store & (count_ext >= eff_cap);

   // broadcast to the cells
   assign ctl.cmp_en   = (state_ff == ST_LOOK);
   assign ctl.upd_en   = upd_fire & (hit | is_store);
   assign ctl.hit_mode = hit;
   assign ctl.evict    = evict;
   assign ctl.cmp_key  = req_ff.key;

   // entry that goes to the head
   assign head_link.valid = 1'b1;
   assign head_link.key   = req_ff.key;
   assign head_link.value = (hit & ~is_store) ? head_sum.hit_value : req_ff.data_in;

   lrukv_row #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_row (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .head_link (head_link),
      .head_sum  (head_sum)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            state_in = ST_UPD;
         end
         ST_UPD: begin
            if (out_free) begin
               state_in = req_valid ? ST_LOOK : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // entry count
   always_comb begin
      count_in = count_ff;
      if (upd_fire && !hit && is_store && !evict) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end
   end

   // result item
   always_comb begin
      rsp_in.hit         = hit;
      rsp_in.data_out    = (hit & ~is_store) ? head_sum.hit_value : '0;
      rsp_in.evicted     = evict;
      rsp_in.evicted_key = evict ? head_sum.last_key : '0;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (upd_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         cap_ff       <= lrukv_pkg::CAP_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         if (csr_valid && csr_ready) begin
            cap_ff <= csr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         req_ff <= req_data;
      end
      if (upd_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ext <= CMP_W'(MAX_ENTRIES))
      else $error("entry count above row length");

   a_look_then_upd: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOK) |=> (state_ff == ST_UPD))
      else $error("compare cycle not followed by update");

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      upd_fire |=> !(rsp_ff.hit && rsp_ff.evicted))
      else $error("result both hit and evicted");

   a_evict_full: assert property (@(posedge clock) disable iff (reset)
      (upd_fire && evict) |=> ($stable(count_ff) && count_ff != '0))
      else $error("eviction changed count or emptied the row");

endmodule
